@@ sv/tbbf_pkg.sv @@
// Types and constants shared by the transmit buffer byte fetch block.
// No dependencies; imported by every module of the block.
package tbbf_pkg;

    localparam int BLOCK_BYTES      = 64;
    localparam int WORDS_PER_BLOCK  = 8;
    localparam int MAX_BUFFER_IDS   = 16;
    localparam int PTR_W            = 14;
    localparam int SHORT_BASE       = 50;
    localparam int SHORT_FIRST_WORD = SHORT_BASE / 8;
    localparam int SHORT_SKEW       = SHORT_BASE % 8;
    localparam int EXT_LEAD         = 8;
    localparam int FULL_COUNT       = 64;
    localparam int QDEPTH           = 4;
    localparam int QPW              = 2;

    localparam logic [7:0] BE_NONE       = 8'h00;
    localparam logic [7:0] BE_ALL        = 8'hFF;
    localparam logic [7:0] BE_SHORT_HEAD = 8'(8'hFF << SHORT_SKEW);
    localparam logic [2:0] LAST_WORD     = 3'd7;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EMPTY,
        CMD_FETCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  buf_id;
        logic [10:0] word;
        logic [7:0]  blk;
        logic [7:0]  nxt;
        logic [6:0]  ext_off;
        logic        full;
        logic [63:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_ZERO,
        ST_LOAD0,
        ST_LOAD1,
        ST_RUN
    } back_state_t;

endpackage

@@ sv/transmit_buffer_byte_fetch_core.sv @@
// Queue empty, back end idle: a full data packet passes the queue, the IDLE pop and the
// LOAD0 and LOAD1 reads to the output register; others load their first word in the ZERO
// or EMPTY state after the pop. A data packet holds the back end for 8 words, one per cycle
// while the output is free, plus two priming reads; an empty packet one word, a buffer
// write its pop only; a 4-entry queue sits between. Reset clears byte pointers, queue and
// sequencer; buffer contents are undefined until written and get no clearing pass.
module transmit_buffer_byte_fetch_core #(
    parameter int NUM_BUFFERS       = 16,
    parameter int BLOCKS_PER_BUFFER = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [3:0]  buffer_id,
    input  logic [10:0] word_index,
    input  logic [63:0] word_data,
    input  logic        is_data,
    input  logic [6:0]  byte_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_word_index,
    output logic [63:0] out_data,
    output logic [7:0]  byte_enable,
    output logic        last
);
    import tbbf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    tbbf_front #(
        .NUM_BUFFERS       (NUM_BUFFERS),
        .BLOCKS_PER_BUFFER (BLOCKS_PER_BUFFER)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .buffer_id  (buffer_id),
        .word_index (word_index),
        .word_data  (word_data),
        .is_data    (is_data),
        .byte_count (byte_count),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    tbbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    tbbf_back #(
        .NUM_BUFFERS       (NUM_BUFFERS),
        .BLOCKS_PER_BUFFER (BLOCKS_PER_BUFFER)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word_index (out_word_index),
        .out_data       (out_data),
        .byte_enable    (byte_enable),
        .last           (last)
    );

endmodule

@@ sv/tbbf_front.sv @@
// Front end: accepts input transfers, keeps the per-buffer byte pointers,
// classifies items into commands for the queue. Depends on tbbf_pkg.
module tbbf_front #(
    parameter int NUM_BUFFERS       = 16,
    parameter int BLOCKS_PER_BUFFER = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [3:0]          buffer_id,
    input  logic [10:0]         word_index,
    input  logic [63:0]         word_data,
    input  logic                is_data,
    input  logic [6:0]          byte_count,
    input  logic                q_full,
    output logic                q_push,
    output tbbf_pkg::cmd_t      q_cmd
);
    import tbbf_pkg::*;

    localparam int NB_USED = (NUM_BUFFERS < MAX_BUFFER_IDS) ? NUM_BUFFERS : MAX_BUFFER_IDS;
    localparam int PIW     = (NB_USED > 1) ? $clog2(NB_USED) : 1;
    localparam int WPB     = BLOCKS_PER_BUFFER * WORDS_PER_BLOCK;

    function automatic logic [255:0][7:0] build_mod_tbl();
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i % BLOCKS_PER_BUFFER);
        end
        return t;
    endfunction

    localparam logic [255:0][7:0] MOD_TBL = build_mod_tbl();

    logic [PTR_W-1:0] ptr_reg [NB_USED];
    logic [PTR_W-1:0] ptr_cur;
    logic [PTR_W-1:0] ptr_next;
    logic [PIW-1:0]   pidx;
    logic             accept;
    logic             buf_ok;
    logic             wr_ok;
    logic             fetch;
    logic [7:0]       blk;
    logic [7:0]       nxt;
    logic             full;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pidx     = buffer_id[PIW-1:0];
    assign buf_ok   = 32'(buffer_id) < NUM_BUFFERS;
    assign wr_ok    = buf_ok && (32'(word_index) < WPB);
    assign fetch    = opcode && is_data && (byte_count != 7'd0) && buf_ok;
    assign ptr_cur  = ptr_reg[pidx];
    assign ptr_next = ptr_cur + PTR_W'(byte_count);
    assign full     = byte_count == 7'(FULL_COUNT);
    assign blk      = MOD_TBL[ptr_cur[PTR_W-1:6]];
    assign nxt      = (32'(blk) == BLOCKS_PER_BUFFER - 1) ? 8'd0 : blk + 8'd1;

    always_comb
    begin
        q_cmd.buf_id = buffer_id;
        q_cmd.word   = word_index;
        q_cmd.data   = word_data;
        q_cmd.blk    = blk;
        q_cmd.nxt    = nxt;
        q_cmd.full   = full;
        if (full)
        begin
            q_cmd.ext_off = 7'(ptr_cur[5:0]) + 7'(EXT_LEAD);
        end
        else
        begin
            q_cmd.ext_off = 7'(ptr_cur[5:0]) + 7'(EXT_LEAD - SHORT_SKEW);
        end
        if (!opcode)
        begin
            q_cmd.kind = CMD_WRITE;
        end
        else if (fetch)
        begin
            q_cmd.kind = CMD_FETCH;
        end
        else
        begin
            q_cmd.kind = CMD_EMPTY;
        end
        q_push = accept && (opcode || wr_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB_USED; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else if (accept && fetch)
        begin
            ptr_reg[pidx] <= ptr_next;
        end
    end

endmodule

@@ sv/tbbf_queue.sv @@
// Short command queue between the front and back ends.
// Depends on tbbf_pkg for the command type and depth.
module tbbf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tbbf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tbbf_pkg::cmd_t head
);
    import tbbf_pkg::*;

    cmd_t           slot_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW:0]   count_reg;
    logic [QPW:0]   count_next;

    assign full  = count_reg == (QPW + 1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/tbbf_back.sv @@
// Back end: buffer memory, fetch sequencer and output register.
// Depends on tbbf_pkg; fed by tbbf_queue.
module tbbf_back #(
    parameter int NUM_BUFFERS       = 16,
    parameter int BLOCKS_PER_BUFFER = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  tbbf_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     out_word_index,
    output logic [63:0]    out_data,
    output logic [7:0]     byte_enable,
    output logic           last
);
    import tbbf_pkg::*;

    localparam int NB_USED = (NUM_BUFFERS < MAX_BUFFER_IDS) ? NUM_BUFFERS : MAX_BUFFER_IDS;
    localparam int WPB     = BLOCKS_PER_BUFFER * WORDS_PER_BLOCK;
    localparam int DEPTH   = NB_USED * WPB;
    localparam int AW      = $clog2(DEPTH);
    localparam int BLKW    = $clog2(BLOCKS_PER_BUFFER);

    function automatic logic [AW-1:0] phys_addr(logic [3:0] buf_id, logic [10:0] word);
        logic [15:0] a;
        a = 16'(buf_id) * 16'(WPB) + 16'(word);
        return a[AW-1:0];
    endfunction

    logic [63:0]  mem [DEPTH];
    back_state_t  state_reg;
    back_state_t  state_next;
    cmd_t         cmd_reg;
    logic [2:0]   k_reg;
    logic [2:0]   k_next;
    logic [4:0]   ext_reg;
    logic [4:0]   ext_next;
    logic [63:0]  prev_reg;
    logic [63:0]  rd_data_reg;
    logic         out_valid_reg;
    logic [2:0]   idx_reg;
    logic [63:0]  data_reg;
    logic [7:0]   be_reg;
    logic         last_reg;

    logic         out_free;
    logic         out_load;
    logic [2:0]   load_idx;
    logic [63:0]  load_data;
    logic [7:0]   load_be;
    logic         load_last;
    logic         cmd_load;
    logic         prev_load;
    logic         mem_we;
    logic         rd_en;
    logic [4:0]   rd_ext;
    logic [3:0]   rd_wi;
    logic [7:0]   rd_blk;
    logic [AW-1:0] rd_addr;
    logic [127:0] win;
    logic [63:0]  shifted;

    assign out_free = !out_valid_reg || out_ready;

    assign rd_wi   = 4'(rd_ext - 5'd1);
    assign rd_blk  = rd_wi[3] ? cmd_reg.nxt : cmd_reg.blk;
    assign rd_addr = phys_addr(cmd_reg.buf_id, 11'({rd_blk[BLKW-1:0], rd_wi[2:0]}));

    assign win     = {rd_data_reg, prev_reg};
    assign shifted = 64'(win >> {cmd_reg.ext_off[2:0], 3'b000});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind)
                        CMD_WRITE: state_next = ST_IDLE;
                        CMD_EMPTY: state_next = ST_EMPTY;
                        CMD_FETCH: state_next = q_head.full ? ST_LOAD0 : ST_ZERO;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ZERO:
            begin
                if (out_free && k_reg == 3'(SHORT_FIRST_WORD - 1))
                begin
                    state_next = ST_LOAD0;
                end
            end
            ST_LOAD0: state_next = ST_LOAD1;
            ST_LOAD1: state_next = ST_RUN;
            ST_RUN:
            begin
                if (out_free && k_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        cmd_load  = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        rd_ext    = ext_reg;
        prev_load = 1'b0;
        out_load  = 1'b0;
        load_idx  = k_reg;
        load_data = '0;
        load_be   = BE_NONE;
        load_last = 1'b0;
        k_next    = k_reg;
        ext_next  = ext_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_load = 1'b1;
                    mem_we   = q_head.kind == CMD_WRITE;
                    k_next   = '0;
                end
            end
            ST_EMPTY:
            begin
                out_load  = out_free;
                load_idx  = '0;
                load_last = 1'b1;
            end
            ST_ZERO:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_LOAD0:
            begin
                rd_en    = 1'b1;
                rd_ext   = 5'(cmd_reg.ext_off[6:3]);
                ext_next = 5'(cmd_reg.ext_off[6:3]) + 5'd1;
            end
            ST_LOAD1:
            begin
                rd_en     = 1'b1;
                prev_load = 1'b1;
                ext_next  = ext_reg + 5'd1;
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    prev_load = 1'b1;
                    load_last = k_reg == LAST_WORD;
                    if (!cmd_reg.full && k_reg == 3'(SHORT_FIRST_WORD))
                    begin
                        load_be = BE_SHORT_HEAD;
                    end
                    else
                    begin
                        load_be = BE_ALL;
                    end
                    for (int b = 0; b < 8; b++)
                    begin
                        load_data[8*b +: 8] = load_be[b] ? shifted[8*b +: 8] : 8'd0;
                    end
                    if (k_reg != LAST_WORD)
                    begin
                        rd_en    = 1'b1;
                        ext_next = ext_reg + 5'd1;
                        k_next   = k_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ext_reg   <= ext_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= q_head;
        end
        if (prev_load)
        begin
            prev_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            idx_reg  <= load_idx;
            data_reg <= load_data;
            be_reg   <= load_be;
            last_reg <= load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[phys_addr(q_head.buf_id, q_head.word)] <= q_head.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_word_index = idx_reg;
    assign out_data       = data_reg;
    assign byte_enable    = be_reg;
    assign last           = last_reg;

`ifndef SYNTH
    a_last_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> idx_reg == LAST_WORD || (idx_reg == '0 && be_reg == BE_NONE))
        else $error("last flag on unexpected word");

    a_stall_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && !out_free |=> $stable(rd_data_reg) && $stable(prev_reg))
        else $error("fetch window changed during output stall");

    a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_ext <= 5'd16)
        else $error("read beyond two-block window");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_IDLE && !out_load && !rd_en)
        else $error("buffer write overlaps a fetch");
`endif

endmodule
